[rtl/core/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the SHA-1 digest core.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned RoundW = 7;
  localparam int unsigned FillW  = 6;
  localparam int unsigned TotalW = 61;
  localparam int unsigned LenW   = 64;

  typedef logic [WordW-1:0] word_t;

  // five working or chaining words, a first
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } work_t;

  // byte and roll requests toward the message schedule
  typedef struct packed {
    logic       byte_en;
    logic       word_end;
    logic [7:0] byte_val;
    logic       roll;
  } sched_ctrl_t;

  localparam work_t InitChain = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam logic [RoundW-1:0] Rounds   = 7'd80;
  localparam logic [7:0]        PadByte  = 8'h80;
  localparam logic [FillW-1:0]  PadFill  = 6'd56;
  localparam logic [FillW-1:0]  FillLast = 6'd63;
  localparam logic [3:0]        LenBytes = 4'd8;

  function automatic word_t rotl(word_t x, int unsigned s);
    return (x << s) | (x >> (WordW - s));
  endfunction

  // round function by round group
  function automatic word_t round_f(logic [RoundW-1:0] t, word_t b, word_t c, word_t d);
    word_t f;
    if (t inside {[7'd0:7'd19]}) begin
      f = (b & c) | (~b & d);
    end else if (t inside {[7'd40:7'd59]}) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // round constant by round group
  function automatic word_t round_k(logic [RoundW-1:0] t);
    word_t k;
    if (t inside {[7'd0:7'd19]}) begin
      k = K0;
    end else if (t inside {[7'd20:7'd39]}) begin
      k = K1;
    end else if (t inside {[7'd40:7'd59]}) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

[rtl/core/sha1_digest.sv]
// ----------------------------------------------------------------------------
// sha1_digest
// SHA-1 over a byte stream: packs bytes, compresses each 64-byte block with
// one shared round unit, pads the message and returns the five digest words.
// ----------------------------------------------------------------------------
//  channel | direction | beat holds
//  in      | sink      | data_byte, has_byte, last_byte
//  out     | source    | digest_word, word_index, last_word
//
// A byte that does not close a block is taken in the idle state. A byte that
// closes a 64-byte block is accepted, then runs the 80 rounds on the shared
// round unit, then is folded into the chain. A last beat adds padding at one
// byte per cycle, except while a padded block compresses, then five output beats.
// Reset is asynchronous and active low and restores the initial chain value.
// Input is not ready while a block compresses, padding runs or words go out;
// a stalled output beat holds the core.
module sha1_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha1_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_COMP = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_PAD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  work_t               chain_q, chain_d;
  work_t               work_q, work_d;
  work_t               work_next;
  logic [TotalW-1:0]   total_q, total_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [RoundW-1:0]   round_q, round_d;
  logic                pad_q, pad_d;
  logic                sent80_q, sent80_d;
  logic [3:0]          lencnt_q, lencnt_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [2:0]          widx_q, widx_d;
  word_t               w;
  sched_ctrl_t         sched_ctrl;
  logic                in_acc, out_acc, wrap;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  // byte source: input beat or padding
  always_comb begin
    sched_ctrl          = '0;
    sched_ctrl.word_end = (fill_q[1:0] == 2'd3);
    sched_ctrl.roll     = (state_q == ST_COMP);
    if (state_q == ST_IDLE) begin
      sched_ctrl.byte_en  = in_acc && has_byte_i;
      sched_ctrl.byte_val = data_byte_i;
    end else if (state_q == ST_PAD) begin
      sched_ctrl.byte_en = 1'b1;
      if (!sent80_q) begin
        sched_ctrl.byte_val = PadByte;
      end else if (lencnt_q == '0 && fill_q != PadFill) begin
        sched_ctrl.byte_val = '0;
      end else begin
        sched_ctrl.byte_val = len_q[LenW-1 -: 8];
      end
    end
  end

  assign wrap = sched_ctrl.byte_en && (fill_q == FillLast);

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w)
  );

  sha1_round u_round (
    .work_i  (work_q),
    .w_i     (w),
    .round_i (round_q),
    .work_o  (work_next)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    chain_d  = chain_q;
    work_d   = work_q;
    total_d  = total_q;
    fill_d   = fill_q;
    round_d  = round_q;
    pad_d    = pad_q;
    sent80_d = sent80_q;
    lencnt_d = lencnt_q;
    len_d    = len_q;
    widx_d   = widx_q;
    if (sched_ctrl.byte_en) begin
      fill_d = fill_q + 6'd1;
    end
    if (wrap) begin
      work_d  = chain_q;
      round_d = '0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_byte_i) begin
            total_d = total_q + 61'd1;
          end
          if (last_byte_i) begin
            pad_d    = 1'b1;
            sent80_d = 1'b0;
            lencnt_d = '0;
            len_d    = {total_d, 3'b000};
          end
          if (wrap) begin
            state_d = ST_COMP;
          end else if (last_byte_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        work_d  = work_next;
        round_d = round_q + 7'd1;
        if (round_q == Rounds - 7'd1) begin
          round_d = '0;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_d.a = chain_q.a + work_q.a;
        chain_d.b = chain_q.b + work_q.b;
        chain_d.c = chain_q.c + work_q.c;
        chain_d.d = chain_q.d + work_q.d;
        chain_d.e = chain_q.e + work_q.e;
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (lencnt_q == LenBytes) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (!sent80_q) begin
          sent80_d = 1'b1;
        end else if (!(lencnt_q == '0 && fill_q != PadFill)) begin
          lencnt_d = lencnt_q + 4'd1;
          len_d    = {len_q[LenW-9:0], 8'h00};
        end
        if (wrap) begin
          state_d = ST_COMP;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd4) begin
            widx_d  = '0;
            chain_d = InitChain;
            total_d = '0;
            fill_d  = '0;
            pad_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      chain_q  <= InitChain;
      total_q  <= '0;
      fill_q   <= '0;
      round_q  <= '0;
      pad_q    <= 1'b0;
      sent80_q <= 1'b0;
      lencnt_q <= '0;
      widx_q   <= '0;
    end else begin
      state_q  <= state_d;
      chain_q  <= chain_d;
      total_q  <= total_d;
      fill_q   <= fill_d;
      round_q  <= round_d;
      pad_q    <= pad_d;
      sent80_q <= sent80_d;
      lencnt_q <= lencnt_d;
      widx_q   <= widx_d;
    end
  end

  // working words and length shifter
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    len_q  <= len_d;
  end

  // output word select
  always_comb begin
    case (widx_q)
      3'd0:    digest_word_o = chain_q.a;
      3'd1:    digest_word_o = chain_q.b;
      3'd2:    digest_word_o = chain_q.c;
      3'd3:    digest_word_o = chain_q.d;
      3'd4:    digest_word_o = chain_q.e;
      default: digest_word_o = '0;
    endcase
  end

  assign word_index_o = widx_q;
  assign last_word_o  = (widx_q == 3'd4);

  // checks
  a_ready_xor_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest words are pending");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP) |-> (round_q < Rounds))
    else $error("round counter out of range");

  a_last_round_adds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && round_q == Rounds - 7'd1) |=> (state_q == ST_ADD))
    else $error("chain update missing after last round");

  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=> !in_ready_o)
    else $error("input taken again before digest of closed message");

  a_done_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word_o) |=> (in_ready_o && fill_q == '0 && total_q == '0))
    else $error("core not cleared after final digest word");

endmodule

[rtl/core/sha1_round.sv]
// ----------------------------------------------------------------------------
// sha1_round
// One SHA-1 round: next working words from the current ones, W and round index.
// ----------------------------------------------------------------------------
module sha1_round (
  input  sha1_pkg::work_t             work_i,
  input  sha1_pkg::word_t             w_i,
  input  logic [sha1_pkg::RoundW-1:0] round_i,
  output sha1_pkg::work_t             work_o
);
  import sha1_pkg::*;

  word_t tmp;

  // five-operand sum of the round
  assign tmp = rotl(work_i.a, 5) + round_f(round_i, work_i.b, work_i.c, work_i.d)
             + work_i.e + round_k(round_i) + w_i;

  // shift the working words down by one, rotating b left by 30 into c
  assign work_o.a = tmp;
  assign work_o.b = work_i.a;
  assign work_o.c = rotl(work_i.b, 30);
  assign work_o.d = work_i.c;
  assign work_o.e = work_i.d;

endmodule

[rtl/core/sha1_sched.sv]
// ----------------------------------------------------------------------------
// sha1_sched
// Byte packer and rolling 16-word message schedule; W of the round is tap 0.
// ----------------------------------------------------------------------------
module sha1_sched (
  input  logic                  clk_i,
  input  sha1_pkg::sched_ctrl_t ctrl_i,
  output sha1_pkg::word_t       w_o
);
  import sha1_pkg::*;

  localparam int unsigned Depth = 16;

  word_t       sched_q [Depth];
  word_t       sched_d [Depth];
  logic [23:0] acc_q;
  logic [23:0] acc_d;
  word_t       new_word;
  logic        shift;

  // expanded word or freshly packed word enters at the top
  assign new_word = ctrl_i.roll
                  ? rotl(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0], 1)
                  : {acc_q, ctrl_i.byte_val};
  assign shift    = ctrl_i.roll || (ctrl_i.byte_en && ctrl_i.word_end);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.byte_en) begin
      acc_d = {acc_q[15:0], ctrl_i.byte_val};
    end
    for (int i = 0; i < Depth - 1; i++) begin
      sched_d[i] = shift ? sched_q[i+1] : sched_q[i];
    end
    sched_d[Depth-1] = shift ? new_word : sched_q[Depth-1];
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    for (int i = 0; i < Depth; i++) begin
      sched_q[i] <= sched_d[i];
    end
  end

  assign w_o = sched_q[0];

endmodule
